// ===== sv/cfd_pkg.sv =====
// ----------------------------------------------------------------------------
// CRC-32 frame deframer package
// Shared types, header layout constants and the byte-wide CRC-32 update.
// ----------------------------------------------------------------------------
package cfd_pkg;

  // Frame parsing phase
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_PAYLOAD = 3'd1,
    PH_SKIP    = 3'd2
  } phase_t;

  // Frame report status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT      = 3'd1,
    ST_MAGIC      = 3'd2,
    ST_INCOMPLETE = 3'd3,
    ST_MISMATCH   = 3'd4
  } status_t;

  // Header layout: byte offsets of each little-endian field
  localparam logic [4:0] HDR_VER_POS = 5'd4;
  localparam logic [4:0] HDR_CMD_POS = 5'd6;
  localparam logic [4:0] HDR_SEQ_POS = 5'd8;
  localparam logic [4:0] HDR_LEN_POS = 5'd12;
  localparam logic [4:0] HDR_CHK_POS = 5'd16;
  localparam logic [4:0] HDR_BYTES   = 5'd20;

  // CRC-32 constants (reflected form)
  localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;

  // Advance a reflected CRC-32 by one byte, LSB first
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                             input logic [7:0]  data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/cfd_stream_if.sv =====
// ----------------------------------------------------------------------------
// CRC-32 frame deframer channel interfaces
// Valid/ready byte input channel and result channel.
// ----------------------------------------------------------------------------
interface cfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_buffer;

  modport source (output valid, output rx_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

interface cfd_out_if;
  logic        valid;
  logic        ready;
  logic        is_report;
  logic [7:0]  payload_byte;
  logic [2:0]  status;
  logic [15:0] version;
  logic [15:0] command;
  logic [31:0] sequence_res;
  logic [31:0] payload_length;
  logic [31:0] received_checksum;
  logic        last;

  modport source (output valid, output is_report, output payload_byte, output status,
                  output version, output command, output sequence_res,
                  output payload_length, output received_checksum, output last,
                  input ready);
  modport sink   (input valid, input is_report, input payload_byte, input status,
                  input version, input command, input sequence_res,
                  input payload_length, input received_checksum, input last,
                  output ready);
endinterface

// ===== sv/crc32_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// CRC-32 frame deframer
// Parses length-prefixed frames with a 20-byte header and CRC-32 payload check.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle while in_ch.ready is high.
// Header bytes are gathered into the frame registers, payload bytes are passed
// on as results while the CRC-32 is updated, and a report closes each frame. A
// byte whose transaction yields one result or none leaves the input ready for
// the next byte whenever the output register is empty or being taken. The
// final payload byte, and a payload byte that ends the buffer early, yield a
// byte result and a report; the report waits in a pending slot behind the
// output register, which holds off the input until the report moves forward.
// Each result shows the header fields as gathered up to and including its byte.
module crc32_frame_deframer (
  input  logic               clk,
  input  logic               rst_n,
  cfd_in_if.sink             in_ch,
  cfd_out_if.source          out_ch,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data
);

  // Configuration register
  logic [31:0] cfg_magic_r;

  // Frame state
  cfd_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]      hdr_idx_r, hdr_idx_nxt;
  logic [31:0]     magic_r, magic_nxt;
  logic [15:0]     ver_r, ver_nxt;
  logic [15:0]     cmd_r, cmd_nxt;
  logic [31:0]     seq_r, seq_nxt;
  logic [31:0]     len_r, len_nxt;
  logic [31:0]     chk_r, chk_nxt;
  logic [31:0]     crc_r, crc_nxt;
  logic [31:0]     cnt_r, cnt_nxt;

  // Results of the current transaction
  logic             emit1, emit2;
  logic             rep1, last1;
  logic [7:0]       byte1;
  cfd_pkg::status_t stat1, stat2;

  // Output register and pending report slot
  logic             ov_r;
  logic             pend_r;
  cfd_pkg::status_t pend_stat_r;
  logic             o_rep_r;
  logic [7:0]       o_byte_r;
  cfd_pkg::status_t o_stat_r;
  logic             o_last_r;
  logic [15:0]      o_ver_r, o_cmd_r;
  logic [31:0]      o_seq_r, o_len_r, o_chk_r;

  logic in_fire, out_fire;
  logic [7:0] b;
  logic eob;

  assign b        = in_ch.rx_byte;
  assign eob      = in_ch.end_of_buffer;
  assign in_ch.ready = !pend_r && (!ov_r || out_ch.ready);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = ov_r && out_ch.ready;

  // Capture expected magic
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_magic_r <= '0;
    end else if (cfg_wr_en) begin
      cfg_magic_r <= cfg_wr_data;
    end
  end

  // Next frame state and results for the byte on the input
  always_comb begin
    phase_nxt   = phase_r;
    hdr_idx_nxt = hdr_idx_r;
    magic_nxt   = magic_r;
    ver_nxt     = ver_r;
    cmd_nxt     = cmd_r;
    seq_nxt     = seq_r;
    len_nxt     = len_r;
    chk_nxt     = chk_r;
    crc_nxt     = crc_r;
    cnt_nxt     = cnt_r;
    emit1       = 1'b0;
    emit2       = 1'b0;
    rep1        = 1'b0;
    last1       = 1'b0;
    byte1       = '0;
    stat1       = cfd_pkg::ST_OK;
    stat2       = cfd_pkg::ST_OK;

    unique case (phase_r)
      cfd_pkg::PH_HEADER: begin
        // Load the header byte into its lane
        if (hdr_idx_r < cfd_pkg::HDR_BYTES) begin
          if (hdr_idx_r < cfd_pkg::HDR_VER_POS) begin
            magic_nxt[{hdr_idx_r[1:0], 3'b000} +: 8] = b;
          end else if (hdr_idx_r < cfd_pkg::HDR_CMD_POS) begin
            ver_nxt[{hdr_idx_r[0], 3'b000} +: 8] = b;
          end else if (hdr_idx_r < cfd_pkg::HDR_SEQ_POS) begin
            cmd_nxt[{hdr_idx_r[0], 3'b000} +: 8] = b;
          end else if (hdr_idx_r < cfd_pkg::HDR_LEN_POS) begin
            seq_nxt[{hdr_idx_r[1:0], 3'b000} +: 8] = b;
          end else if (hdr_idx_r < cfd_pkg::HDR_CHK_POS) begin
            len_nxt[{hdr_idx_r[1:0], 3'b000} +: 8] = b;
          end else begin
            chk_nxt[{hdr_idx_r[1:0], 3'b000} +: 8] = b;
          end
          hdr_idx_nxt = hdr_idx_r + 5'd1;
        end
        // Check the completed header
        if (hdr_idx_nxt >= cfd_pkg::HDR_BYTES) begin
          if (magic_nxt != cfg_magic_r) begin
            emit1 = 1'b1; rep1 = 1'b1; last1 = 1'b1;
            stat1 = cfd_pkg::ST_MAGIC;
            phase_nxt = cfd_pkg::PH_SKIP;
          end else if (len_nxt == '0) begin
            emit1 = 1'b1; rep1 = 1'b1; last1 = 1'b1;
            stat1 = ((crc_r ^ cfd_pkg::CRC_ALL_ONES) == chk_nxt) ?
                    cfd_pkg::ST_OK : cfd_pkg::ST_MISMATCH;
            phase_nxt = cfd_pkg::PH_SKIP;
          end else if (eob) begin
            emit1 = 1'b1; rep1 = 1'b1; last1 = 1'b1;
            stat1 = cfd_pkg::ST_INCOMPLETE;
          end else begin
            phase_nxt = cfd_pkg::PH_PAYLOAD;
          end
        end else if (eob) begin
          emit1 = 1'b1; rep1 = 1'b1; last1 = 1'b1;
          stat1 = cfd_pkg::ST_SHORT;
        end
      end
      cfd_pkg::PH_PAYLOAD: begin
        // Pass the byte on and advance the CRC
        crc_nxt = cfd_pkg::crc32_byte(crc_r, b);
        cnt_nxt = cnt_r + 32'd1;
        emit1   = 1'b1;
        byte1   = b;
        if (cnt_nxt == len_r) begin
          emit2 = 1'b1;
          stat2 = ((crc_nxt ^ cfd_pkg::CRC_ALL_ONES) == chk_r) ?
                  cfd_pkg::ST_OK : cfd_pkg::ST_MISMATCH;
          phase_nxt = cfd_pkg::PH_SKIP;
        end else if (eob) begin
          emit2 = 1'b1;
          stat2 = cfd_pkg::ST_INCOMPLETE;
        end else begin
          last1 = 1'b1;
        end
      end
      default: begin
        // Skip trailing bytes
      end
    endcase
  end

  // Advance frame state; clear it after a byte that ends the buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= cfd_pkg::PH_HEADER;
      hdr_idx_r <= '0;
      magic_r   <= '0;
      ver_r     <= '0;
      cmd_r     <= '0;
      seq_r     <= '0;
      len_r     <= '0;
      chk_r     <= '0;
      crc_r     <= cfd_pkg::CRC_ALL_ONES;
      cnt_r     <= '0;
    end else if (in_fire) begin
      if (eob) begin
        phase_r   <= cfd_pkg::PH_HEADER;
        hdr_idx_r <= '0;
        magic_r   <= '0;
        ver_r     <= '0;
        cmd_r     <= '0;
        seq_r     <= '0;
        len_r     <= '0;
        chk_r     <= '0;
        crc_r     <= cfd_pkg::CRC_ALL_ONES;
        cnt_r     <= '0;
      end else begin
        phase_r   <= phase_nxt;
        hdr_idx_r <= hdr_idx_nxt;
        magic_r   <= magic_nxt;
        ver_r     <= ver_nxt;
        cmd_r     <= cmd_nxt;
        seq_r     <= seq_nxt;
        len_r     <= len_nxt;
        chk_r     <= chk_nxt;
        crc_r     <= crc_nxt;
        cnt_r     <= cnt_nxt;
      end
    end
  end

  // Output valid and pending report control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      pend_r <= 1'b0;
    end else if (in_fire && emit1) begin
      ov_r   <= 1'b1;
      pend_r <= emit2;
    end else if (out_fire) begin
      if (pend_r) begin
        pend_r <= 1'b0;
      end else begin
        ov_r <= 1'b0;
      end
    end
  end

  // Output payload: load a new result, or move the pending report forward
  always_ff @(posedge clk) begin
    if (in_fire && emit1) begin
      o_rep_r     <= rep1;
      o_byte_r    <= byte1;
      o_stat_r    <= stat1;
      o_last_r    <= last1;
      o_ver_r     <= ver_nxt;
      o_cmd_r     <= cmd_nxt;
      o_seq_r     <= seq_nxt;
      o_len_r     <= len_nxt;
      o_chk_r     <= chk_nxt;
      pend_stat_r <= stat2;
    end else if (out_fire && pend_r) begin
      o_rep_r  <= 1'b1;
      o_byte_r <= '0;
      o_stat_r <= pend_stat_r;
      o_last_r <= 1'b1;
    end
  end

  // Drive the result channel
  assign out_ch.valid             = ov_r;
  assign out_ch.is_report         = o_rep_r;
  assign out_ch.payload_byte      = o_byte_r;
  assign out_ch.status            = o_stat_r;
  assign out_ch.version           = o_ver_r;
  assign out_ch.command           = o_cmd_r;
  assign out_ch.sequence_res      = o_seq_r;
  assign out_ch.payload_length    = o_len_r;
  assign out_ch.received_checksum = o_chk_r;
  assign out_ch.last              = o_last_r;

  // A pending report always sits behind a held result
  a_pend_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> ov_r)
    else $error("pending report without a result in the output register");

  // The pending report blocks new input
  a_pend_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !in_ch.ready)
    else $error("input accepted while a report is pending");

  // Taking a byte result with a pending report presents that report next
  a_pend_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && pend_r) |=> (ov_r && o_rep_r && o_last_r))
    else $error("pending report not presented after its byte result");

  // A buffer end returns the parser to an empty header
  a_eob_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && eob) |=> (phase_r == cfd_pkg::PH_HEADER && hdr_idx_r == 5'd0
                           && crc_r == cfd_pkg::CRC_ALL_ONES))
    else $error("frame state not cleared at buffer end");

  // A payload byte result carries no status; its last flag is set only when no report is pending
  a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !o_rep_r) |-> (o_stat_r == cfd_pkg::ST_OK && !pend_r == o_last_r))
    else $error("payload byte result with bad status or last flag");

endmodule
